[hdl/uvs_pkg.sv]
package uvs_pkg;

   localparam int MAX_RINGS       = 64;
   localparam int MAX_SECTORS     = 64;
   localparam int SINE_TABLE_BITS = 10;

   localparam int PHASE_W      = 16;
   localparam int QUARTER_SIZE = 1 << (SINE_TABLE_BITS - 2);
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // dividend is index * 2^PHASE_W, quotient keeps PHASE_W+1 bits
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int DIVIDEND_W = IDX_W + PHASE_W;
   localparam int QUO_W      = PHASE_W + 1;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (DIVIDEND_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int TRIG_STAGES = 4;
   // input register + divider + trig + output register
   localparam int RSP_LATENCY = 1 + DIV_STAGES + TRIG_STAGES + 1;

   localparam int CORNER_W = 12;

   typedef enum logic [1:0] {
      CSR_RING_COUNT    = 2'd0,
      CSR_SECTOR_COUNT  = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] ring_index;
      logic [IDX_W-1:0] sector_index;
   } req_data_type;

   typedef struct packed {
      logic                    point_valid;
      logic signed [15:0]      pos_x;
      logic signed [15:0]      pos_y;
      logic signed [15:0]      pos_z;
      logic [15:0]             tex_u;
      logic [15:0]             tex_v;
      logic                    quad_valid;
      logic [CORNER_W-1:0]     corner_a;
      logic [CORNER_W-1:0]     corner_b;
      logic [CORNER_W-1:0]     corner_c;
      logic [CORNER_W-1:0]     corner_d;
   } rsp_data_type;

   typedef logic [15:0] qw_table_type [0:QUARTER_SIZE];

   // quarter-wave sine, Q30 Taylor series rounded to Q1.15
   function automatic qw_table_type build_qw_table();
      qw_table_type tab;
      logic [63:0]  a;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      for (int j = 0; j <= QUARTER_SIZE; j++) begin
         a    = (PI_HALF_Q30 * 64'(j)) / QUARTER_SIZE;
         term = a;
         sum  = a;
         for (int k = 1; k <= 10; k++) begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tab[j] = v[15:0];
      end
      return tab;
   endfunction

   localparam qw_table_type QW_TABLE = build_qw_table();

   function automatic logic signed [15:0] sine_at(logic [SINE_TABLE_BITS-1:0] idx);
      logic [1:0]                   q;
      logic [SINE_TABLE_BITS-2:0]   j;
      logic signed [15:0]           v;
      q = idx[SINE_TABLE_BITS-1 -: 2];
      j = {1'b0, idx[SINE_TABLE_BITS-3:0]};
      if (q[0]) begin
         j = (SINE_TABLE_BITS-1)'(QUARTER_SIZE) - j;
      end
      v = $signed(QW_TABLE[j]);
      return q[1] ? -v : v;
   endfunction

endpackage

[hdl/uvs_div.sv]
// Pipelined restoring divider: quotient of index * 2^16 by a 6-bit divisor.
module uvs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [uvs_pkg::IDX_W-1:0]   in_index,
   input  logic [uvs_pkg::IDX_W-1:0]   in_divisor,
   output logic                        out_valid,
   output logic [uvs_pkg::QUO_W-1:0]   out_quotient
);

   localparam int N = uvs_pkg::DIV_STAGES;

   logic                        valid_ff [N];
   logic [uvs_pkg::IDX_W-1:0]   index_ff [N];
   logic [uvs_pkg::IDX_W-1:0]   div_ff   [N];
   logic [uvs_pkg::IDX_W-1:0]   rem_ff   [N];
   logic [uvs_pkg::QUO_W-1:0]   quo_ff   [N];
   logic [uvs_pkg::IDX_W-1:0]   rem_in   [N];
   logic [uvs_pkg::QUO_W-1:0]   quo_in   [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic                        src_valid;
      logic [uvs_pkg::IDX_W-1:0]   src_index;
      logic [uvs_pkg::IDX_W-1:0]   src_div;
      logic [uvs_pkg::IDX_W-1:0]   src_rem;
      logic [uvs_pkg::QUO_W-1:0]   src_quo;
      logic [uvs_pkg::DIVIDEND_W-1:0] dividend;
      logic [uvs_pkg::IDX_W:0]     acc;

      if (g == 0) begin : g_src0
         assign src_valid = in_valid;
         assign src_index = in_index;
         assign src_div   = in_divisor;
         assign src_rem   = '0;
         assign src_quo   = '0;
      end else begin : g_srcn
         assign src_valid = valid_ff[g-1];
         assign src_index = index_ff[g-1];
         assign src_div   = div_ff[g-1];
         assign src_rem   = rem_ff[g-1];
         assign src_quo   = quo_ff[g-1];
      end

      assign dividend = {src_index, {uvs_pkg::PHASE_W{1'b0}}};

      always_comb begin
         rem_in[g] = src_rem;
         quo_in[g] = src_quo;
         acc       = '0;
         for (int j = 0; j < uvs_pkg::DIV_STEPS; j++) begin
            if (uvs_pkg::DIVIDEND_W - 1 - uvs_pkg::DIV_STEPS * g - j >= 0) begin
               acc = {rem_in[g],
                      dividend[uvs_pkg::DIVIDEND_W - 1 - uvs_pkg::DIV_STEPS * g - j]};
               if (acc >= {1'b0, src_div}) begin
                  rem_in[g] = uvs_pkg::IDX_W'(acc - {1'b0, src_div});
                  quo_in[g] = {quo_in[g][uvs_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[g] = acc[uvs_pkg::IDX_W-1:0];
                  quo_in[g] = {quo_in[g][uvs_pkg::QUO_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= src_valid;
         end
         index_ff[g] <= src_index;
         div_ff[g]   <= src_div;
         rem_ff[g]   <= rem_in[g];
         quo_ff[g]   <= quo_in[g];
      end
   end

   assign out_valid    = valid_ff[N-1];
   assign out_quotient = quo_ff[N-1];

endmodule

[hdl/uvs_trig.sv]
// Sine/cosine lookup and radius scaling: lookup, two multiply stages, saturate.
module uvs_trig (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [15:0]           ring_phase,
   input  logic [15:0]           sector_phase,
   input  logic [15:0]           radius,
   output logic                  out_valid,
   output logic signed [15:0]    pos_x,
   output logic signed [15:0]    pos_y,
   output logic signed [15:0]    pos_z
);

   localparam int SH = uvs_pkg::PHASE_W - uvs_pkg::SINE_TABLE_BITS;
   localparam logic [uvs_pkg::SINE_TABLE_BITS-1:0] QUARTER_IDX =
      uvs_pkg::SINE_TABLE_BITS'(uvs_pkg::QUARTER_SIZE);

   logic [uvs_pkg::SINE_TABLE_BITS-1:0] it;
   logic [uvs_pkg::SINE_TABLE_BITS-1:0] ip;

   logic signed [16:0] rad_s;
   logic signed [16:0] neg_ct;
   logic signed [31:0] prod_x;
   logic signed [31:0] prod_z;
   logic signed [33:0] prod_y;
   logic signed [33:0] scale_x;
   logic signed [33:0] scale_z;

   logic [3:0]         valid_ff;
   logic signed [15:0] st_ff, ct_ff, sp_ff, cp_ff;
   logic signed [16:0] tx_ff, tz_ff;
   logic signed [18:0] y1_ff, y2_ff, x2_ff, z2_ff;
   logic signed [15:0] x_ff, y_ff, z_ff;

   function automatic logic signed [15:0] sat16(logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   assign it     = ring_phase[uvs_pkg::PHASE_W-1:SH];
   assign ip     = sector_phase[uvs_pkg::PHASE_W-1:SH];
   assign rad_s  = $signed({1'b0, radius});
   assign neg_ct = -$signed({ct_ff[15], ct_ff});
   assign prod_x = cp_ff * st_ff;
   assign prod_z = sp_ff * st_ff;
   assign prod_y = neg_ct * rad_s;
   assign scale_x = tx_ff * rad_s;
   assign scale_z = tz_ff * rad_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      st_ff <= uvs_pkg::sine_at(it);
      ct_ff <= uvs_pkg::sine_at(it + QUARTER_IDX);
      sp_ff <= uvs_pkg::sine_at(ip);
      cp_ff <= uvs_pkg::sine_at(ip + QUARTER_IDX);
      tx_ff <= 17'(prod_x >>> 15);
      tz_ff <= 17'(prod_z >>> 15);
      y1_ff <= 19'(prod_y >>> 15);
      x2_ff <= 19'(scale_x >>> 15);
      z2_ff <= 19'(scale_z >>> 15);
      y2_ff <= y1_ff;
      x_ff  <= sat16(x2_ff);
      y_ff  <= sat16(y2_ff);
      z_ff  <= sat16(z2_ff);
   end

   assign out_valid = valid_ff[3];
   assign pos_x     = x_ff;
   assign pos_y     = y_ff;
   assign pos_z     = z_ff;

endmodule

[hdl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator. One grid point (ring, sector) is taken per
// cycle whenever start is high; busy stays low, so every cycle can take a
// new point. Each point gives exactly one result, shown on rsp_data with the
// rsp_valid strobe once it has passed one input register, an 11-stage
// divider (two quotient bits per stage) forming the ring and sector phases,
// four stages of sine lookup and radius scaling, and one output register.
// The result cannot be held off; take it on the strobe. Change the csr
// registers only while no points are in flight.
module uv_sphere_vertex_generator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  uvs_pkg::req_data_type    req_data,
   output logic                     rsp_valid,
   output uvs_pkg::rsp_data_type    rsp_data,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data
);

   localparam int IW = uvs_pkg::IDX_W;
   localparam int CW = uvs_pkg::CORNER_W;
   // input register + divider + trig, so the side data meets the trig output
   localparam int SIDE_N = 1 + uvs_pkg::DIV_STAGES + uvs_pkg::TRIG_STAGES;

   typedef struct packed {
      logic          point_valid;
      logic          quad_valid;
      logic [CW-1:0] corner_a;
      logic [CW-1:0] corner_b;
      logic [CW-1:0] corner_c;
      logic [CW-1:0] corner_d;
   } side_type;

   logic [uvs_pkg::COUNT_W-1:0] ring_count_ff;
   logic [uvs_pkg::COUNT_W-1:0] sector_count_ff;
   logic [15:0]                 radius_ff;

   logic [uvs_pkg::COUNT_W-1:0] rings;
   logic [uvs_pkg::COUNT_W-1:0] sectors;
   logic                        pv;
   logic                        qv;
   logic [12:0]                 base;
   side_type                    side_in;

   logic                        a_valid_ff;
   logic [IW-1:0]               a_r_ff;
   logic [IW-1:0]               a_s_ff;
   logic [IW-1:0]               a_dr_ff;
   logic [IW-1:0]               a_ds_ff;
   side_type                    side_ff [SIDE_N];

   logic                        dr_valid;
   logic                        ds_valid;
   logic [uvs_pkg::QUO_W-1:0]   quo_r;
   logic [uvs_pkg::QUO_W-1:0]   quo_s;
   logic [15:0]                 tex_u_ff [uvs_pkg::TRIG_STAGES];
   logic [15:0]                 tex_v_ff [uvs_pkg::TRIG_STAGES];

   logic                        t_valid;
   logic signed [15:0]          t_x, t_y, t_z;

   logic                        rsp_valid_ff;
   uvs_pkg::rsp_data_type       rsp_data_ff;
   uvs_pkg::rsp_data_type       rsp_data_in;
   side_type                    side_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= 7'd16;
         sector_count_ff <= 7'd16;
         radius_ff       <= 16'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            uvs_pkg::CSR_RING_COUNT:    ring_count_ff   <= csr_data[6:0];
            uvs_pkg::CSR_SECTOR_COUNT:  sector_count_ff <= csr_data[6:0];
            uvs_pkg::CSR_SPHERE_RADIUS: radius_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rings = ring_count_ff;
      if (ring_count_ff < 7'd2) begin
         rings = 7'd2;
      end else if (ring_count_ff > 7'(uvs_pkg::MAX_RINGS)) begin
         rings = 7'(uvs_pkg::MAX_RINGS);
      end
      sectors = sector_count_ff;
      if (sector_count_ff < 7'd2) begin
         sectors = 7'd2;
      end else if (sector_count_ff > 7'(uvs_pkg::MAX_SECTORS)) begin
         sectors = 7'(uvs_pkg::MAX_SECTORS);
      end
   end

   assign pv   = ({1'b0, req_data.ring_index} < rings) &&
                 ({1'b0, req_data.sector_index} < sectors);
   assign qv   = pv && ({1'b0, req_data.ring_index} < rings - 7'd1) &&
                 ({1'b0, req_data.sector_index} < sectors - 7'd1);
   assign base = 13'(req_data.ring_index) * 13'(sectors) + 13'(req_data.sector_index);

   always_comb begin
      side_in.point_valid = pv;
      side_in.quad_valid  = qv;
      side_in.corner_a    = '0;
      side_in.corner_b    = '0;
      side_in.corner_c    = '0;
      side_in.corner_d    = '0;
      if (qv) begin
         side_in.corner_a = base[CW-1:0];
         side_in.corner_b = CW'(base + 13'd1);
         side_in.corner_d = CW'(base + 13'(sectors));
         side_in.corner_c = CW'(base + 13'(sectors) + 13'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_r_ff     <= req_data.ring_index;
      a_s_ff     <= req_data.sector_index;
      a_dr_ff    <= IW'(rings - 7'd1);
      a_ds_ff    <= IW'(sectors - 7'd1);
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_N; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   uvs_div u_div_ring (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_valid_ff),
      .in_index     (a_r_ff),
      .in_divisor   (a_dr_ff),
      .out_valid    (dr_valid),
      .out_quotient (quo_r)
   );

   uvs_div u_div_sector (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_valid_ff),
      .in_index     (a_s_ff),
      .in_divisor   (a_ds_ff),
      .out_valid    (ds_valid),
      .out_quotient (quo_s)
   );

   uvs_trig u_trig (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dr_valid && ds_valid),
      .ring_phase   (quo_r[16:1]),
      .sector_phase (quo_s[15:0]),
      .radius       (radius_ff),
      .out_valid    (t_valid),
      .pos_x        (t_x),
      .pos_y        (t_y),
      .pos_z        (t_z)
   );

   always_ff @(posedge clock) begin
      tex_u_ff[0] <= quo_s[16:1];
      tex_v_ff[0] <= quo_r[16:1];
      for (int i = 1; i < uvs_pkg::TRIG_STAGES; i++) begin
         tex_u_ff[i] <= tex_u_ff[i-1];
         tex_v_ff[i] <= tex_v_ff[i-1];
      end
   end

   assign side_out = side_ff[SIDE_N-1];

   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.quad_valid  = side_out.quad_valid;
      rsp_data_in.corner_a    = side_out.corner_a;
      rsp_data_in.corner_b    = side_out.corner_b;
      rsp_data_in.corner_c    = side_out.corner_c;
      rsp_data_in.corner_d    = side_out.corner_d;
      if (side_out.point_valid) begin
         rsp_data_in.point_valid = 1'b1;
         rsp_data_in.pos_x       = t_x;
         rsp_data_in.pos_y       = t_y;
         rsp_data_in.pos_z       = t_z;
         rsp_data_in.tex_u       = tex_u_ff[uvs_pkg::TRIG_STAGES-1];
         rsp_data_in.tex_v       = tex_v_ff[uvs_pkg::TRIG_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= t_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/uvs_checker.sv]
module uvs_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     rsp_valid,
   input  uvs_pkg::rsp_data_type    rsp_data
);

   // every accepted transaction produces a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(uvs_pkg::RSP_LATENCY) rsp_valid)
      else $error("accepted transaction produced no result");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.point_valid |->
         rsp_data.pos_x == 16'sd0 && rsp_data.pos_y == 16'sd0 &&
         rsp_data.pos_z == 16'sd0 && rsp_data.tex_u == 16'd0 &&
         rsp_data.tex_v == 16'd0 && !rsp_data.quad_valid)
      else $error("out-of-range point carries data");

   a_quad_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.quad_valid |->
         rsp_data.corner_b == rsp_data.corner_a + 12'd1 &&
         rsp_data.corner_c == rsp_data.corner_d + 12'd1)
      else $error("quad corners not adjacent");

   a_no_quad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.quad_valid |->
         rsp_data.corner_a == 12'd0 && rsp_data.corner_b == 12'd0 &&
         rsp_data.corner_c == 12'd0 && rsp_data.corner_d == 12'd0)
      else $error("corners set without a quad");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
